// File: design/layer_keyframe_interpolator_top_assert.svh
// Assertion macros for the layer keyframe interpolator checker.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef LAYER_KEYFRAME_INTERPOLATOR_TOP_ASSERT_SVH
`define LAYER_KEYFRAME_INTERPOLATOR_TOP_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define LKI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define LKI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: design/lki_pkg.sv
// Shared types and constants for the layer keyframe interpolator.
// No dependencies; used by the top level and its port checker.
package lki_pkg;

	// Stream widths, fixed by the field layout.
	localparam int S_TDATA_W = 80;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 32;

	// Fraction width of the blend factor and the smoothstep scale.
	localparam int FRAC_BITS = 8;
	localparam int SMOOTH_K  = 768;

	// Request kinds carried on s_tuser.
	typedef enum logic [1:0] {
		REQ_KEY_WR   = 2'd0,
		REQ_LAYER_WR = 2'd1,
		REQ_QUERY    = 2'd2
	} req_t;

	// Interpolation modes; the fourth code behaves as linear.
	typedef enum logic [1:0] {
		MODE_CONST  = 2'd0,
		MODE_LINEAR = 2'd1,
		MODE_SMOOTH = 2'd2
	} mode_t;

	// Input beat layout, last declared field in the lowest bits.
	typedef struct packed {
		logic [4:0]         pad;
		logic [1:0]         interp_mode;
		logic [8:0]         key_count;
		logic [7:0]         first_key;
		logic signed [15:0] key_off_y;
		logic signed [15:0] key_off_x;
		logic [15:0]        frame;
		logic [7:0]         index;
	} in_beat_t;

	// Output beat layout.
	typedef struct packed {
		logic signed [15:0] off_y;
		logic signed [15:0] off_x;
	} out_beat_t;

	// One keyframe store entry.
	typedef struct packed {
		logic signed [15:0] y;
		logic signed [15:0] x;
		logic [15:0]        frame;
	} key_t;

	// One layer table entry.
	typedef struct packed {
		logic [1:0] mode;
		logic [8:0] count;
		logic [7:0] first;
	} layer_t;

endpackage

// File: design/layer_keyframe_interpolator_top.sv
// Layer keyframe interpolator: keyframe store, layer table and offset query engine.
// Depends on lki_pkg for beat layouts, entry types and request codes.
//
// Usage:
// Every input beat on the s_ side carries one request, its kind on s_tuser.
// A keyframe write or a layer descriptor write gives no
// output beat; s_tready stays high afterwards. A query reads the layer entry,
// checks the last and the first keyframe, then walks the keyframe pairs of
// the layer one per cycle. A bracketing pair goes through a 9-step restoring
// divider for the blend factor, and one shared 18x18 multiplier then forms
// the smoothstep curve and the x and y blends in turn.
// Query paths to the loaded output register: a layer outside the table or
// an empty layer goes straight there; a frame at or beyond the ends holds
// that end keyframe; constant mode skips the divider, and smoothstep adds
// the curve steps to the linear blend. With KEY_DEPTH below 256 the first
// key address is reduced by repeated subtraction.
// One query is in work at a time; s_tready is low while it runs.
// The result sits in an output register, so the next request is taken while
// a result still waits on m_tready. A stalled receiver holds a finished query
// until the register frees. Reset clears the sequencer and m_tvalid; the
// keyframe store and layer table keep no reset and must be written first.
module layer_keyframe_interpolator_top #(
	parameter int KEY_DEPTH   = 256,
	parameter int LAYER_COUNT = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// index, frame, key_off_x, key_off_y, first_key, key_count, interp_mode, zero pad
	input  logic [lki_pkg::S_TDATA_W-1:0] s_tdata,
	// req_type
	input  logic [lki_pkg::S_TUSER_W-1:0] s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// off_x, off_y
	output logic [lki_pkg::M_TDATA_W-1:0] m_tdata
);

	localparam int KAW = $clog2(KEY_DEPTH);
	localparam int LAW = (LAYER_COUNT > 1) ? $clog2(LAYER_COUNT) : 1;
	localparam int BW  = (KAW > 8) ? KAW : 8;
	localparam int SW  = BW + 2;

	typedef enum logic [13:0] {
		S_IDLE   = 14'h0001,
		S_LAYER  = 14'h0002,
		S_REDUCE = 14'h0004,
		S_CHKL   = 14'h0008,
		S_CHKF   = 14'h0010,
		S_SCAN   = 14'h0020,
		S_DIV    = 14'h0040,
		S_SQ     = 14'h0080,
		S_CUBE   = 14'h0100,
		S_SSU    = 14'h0200,
		S_MX     = 14'h0400,
		S_MY     = 14'h0800,
		S_FY     = 14'h1000,
		S_OUT    = 14'h2000
	} state_t;

	state_t state_q, state_d;

	lki_pkg::in_beat_t beat;
	logic              accept;
	logic              is_query;
	logic              layer_ok;

	// Stores and their registered read data.
	lki_pkg::key_t     key_mem [KEY_DEPTH];
	lki_pkg::layer_t   layer_mem [LAYER_COUNT];
	lki_pkg::key_t     key_rd_q;
	lki_pkg::layer_t   layer_rd_q;
	logic [KAW-1:0]    rd_addr;

	// Query working registers.
	logic [15:0]       t_q;
	logic [BW-1:0]     base_q;
	logic [8:0]        n_q;
	logic [1:0]        mode_q;
	logic [KAW-1:0]    cur_q;
	logic [8:0]        i_q;
	lki_pkg::key_t     key_a_q;
	lki_pkg::key_t     key_b_q;
	logic [15:0]       span_q;
	logic [16:0]       rem_q;
	logic [8:0]        quo_q;
	logic [3:0]        cnt_q;
	logic signed [35:0] prod_q;
	logic [15:0]       res_x_q;
	logic [15:0]       res_y_q;
	logic              m_tvalid_q;
	logic [lki_pkg::M_TDATA_W-1:0] m_tdata_q;

	// Combinational helpers.
	logic [8:0]        n_sat;
	logic [KAW-1:0]    cur_inc;
	logic [SW-1:0]     sum_last;
	logic [KAW-1:0]    last_addr;
	logic              base_big;
	logic              in_pair;
	logic              scan_more;
	logic [15:0]       span;
	logic [16:0]       trial;
	logic              ge;
	logic [9:0]        smooth_w;
	logic [16:0]       dx;
	logic [16:0]       dy;
	logic signed [17:0] op_a;
	logic signed [17:0] op_b;
	logic              out_free;

	// Input beat decode.
	assign beat     = lki_pkg::in_beat_t'(s_tdata);
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign is_query = (s_tuser == lki_pkg::REQ_QUERY);
	assign layer_ok = (int'(beat.index) < LAYER_COUNT);
	assign out_free = !m_tvalid_q || m_tready;

	// Key count saturated to the store depth.
	assign n_sat = (int'(layer_rd_q.count) > KEY_DEPTH) ? 9'(KEY_DEPTH) : layer_rd_q.count;

	// Address arithmetic modulo the store depth.
	assign cur_inc   = (cur_q == KAW'(KEY_DEPTH - 1)) ? '0 : cur_q + 1'b1;
	assign base_big  = ({1'b0, base_q} >= (BW + 1)'(KEY_DEPTH));
	assign sum_last  = SW'(base_q) + SW'(n_q - 9'd1);
	assign last_addr = (sum_last >= SW'(KEY_DEPTH)) ? KAW'(sum_last - SW'(KEY_DEPTH))
		: KAW'(sum_last);

	// Pair test and scan bound.
	assign in_pair   = (t_q >= key_a_q.frame) && (t_q <= key_rd_q.frame);
	assign scan_more = ((10'(i_q) + 10'd2) < 10'(n_q));
	assign span      = key_rd_q.frame - key_a_q.frame;

	// Restoring divider step; the first step takes the remainder unshifted.
	assign trial = (cnt_q == 4'd0) ? rem_q : {rem_q[15:0], 1'b0};
	assign ge    = (trial >= {1'b0, span_q});

	// Operands of the shared multiplier.
	assign smooth_w = 10'(lki_pkg::SMOOTH_K) - {quo_q, 1'b0};
	assign dx       = {key_b_q.x[15], key_b_q.x} - {key_a_q.x[15], key_a_q.x};
	assign dy       = {key_b_q.y[15], key_b_q.y} - {key_a_q.y[15], key_a_q.y};

	always_comb begin
		op_a = '0;
		op_b = '0;
		case (state_q)
			S_SQ: begin
				op_a = 18'(quo_q);
				op_b = 18'(quo_q);
			end
			S_CUBE: begin
				op_a = {1'b0, prod_q[16:0]};
				op_b = 18'(smooth_w);
			end
			S_MX: begin
				op_a = {dx[16], dx};
				op_b = 18'(quo_q);
			end
			S_MY: begin
				op_a = {dy[16], dy};
				op_b = 18'(quo_q);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	// Keyframe store read address for the next cycle.
	always_comb begin
		case (state_q)
			S_REDUCE: rd_addr = last_addr;
			S_CHKL:   rd_addr = cur_q;
			default:  rd_addr = cur_inc;
		endcase
	end

	// Keyframe store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (accept && (s_tuser == lki_pkg::REQ_KEY_WR) && (int'(beat.index) < KEY_DEPTH)) begin
			key_mem[KAW'(beat.index)] <= '{y: beat.key_off_y, x: beat.key_off_x,
				frame: beat.frame};
		end
		key_rd_q <= key_mem[rd_addr];
	end

	// Layer table: written and read at the accepted beat's layer.
	always_ff @(posedge clk) begin
		if (accept && (s_tuser == lki_pkg::REQ_LAYER_WR) && layer_ok) begin
			layer_mem[LAW'(beat.index)] <= '{mode: beat.interp_mode, count: beat.key_count,
				first: beat.first_key};
		end
		if (accept) begin
			layer_rd_q <= layer_mem[LAW'(beat.index)];
		end
	end

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && is_query) begin
					state_d = layer_ok ? S_LAYER : S_OUT;
				end
			end
			S_LAYER:  state_d = (n_sat == 9'd0) ? S_OUT : S_REDUCE;
			S_REDUCE: state_d = base_big ? S_REDUCE : S_CHKL;
			S_CHKL:   state_d = (t_q >= key_rd_q.frame) ? S_OUT : S_CHKF;
			S_CHKF:   state_d = (t_q <= key_rd_q.frame) ? S_OUT : S_SCAN;
			S_SCAN: begin
				if (in_pair) begin
					state_d = (mode_q == lki_pkg::MODE_CONST) ? S_OUT : S_DIV;
				end else begin
					state_d = scan_more ? S_SCAN : S_OUT;
				end
			end
			S_DIV: begin
				if (cnt_q == 4'(lki_pkg::FRAC_BITS)) begin
					state_d = (mode_q == lki_pkg::MODE_SMOOTH) ? S_SQ : S_MX;
				end
			end
			S_SQ:   state_d = S_CUBE;
			S_CUBE: state_d = S_SSU;
			S_SSU:  state_d = S_MX;
			S_MX:   state_d = S_MY;
			S_MY:   state_d = S_FY;
			S_FY:   state_d = S_OUT;
			S_OUT:  state_d = out_free ? S_IDLE : S_OUT;
			default: state_d = S_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == S_OUT) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Datapath registers, stepped by the sequencer.
	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
		case (state_q)
			S_IDLE: begin
				res_x_q <= '0;
				res_y_q <= '0;
				if (accept) begin
					t_q <= beat.frame;
				end
			end
			S_LAYER: begin
				base_q <= BW'(layer_rd_q.first);
				n_q    <= n_sat;
				mode_q <= layer_rd_q.mode;
			end
			S_REDUCE: begin
				if (base_big) begin
					base_q <= base_q - BW'(KEY_DEPTH);
				end else begin
					cur_q <= KAW'(base_q);
				end
			end
			S_CHKL: begin
				if (t_q >= key_rd_q.frame) begin
					res_x_q <= key_rd_q.x;
					res_y_q <= key_rd_q.y;
				end
			end
			S_CHKF: begin
				key_a_q <= key_rd_q;
				cur_q   <= cur_inc;
				i_q     <= '0;
				if (t_q <= key_rd_q.frame) begin
					res_x_q <= key_rd_q.x;
					res_y_q <= key_rd_q.y;
				end
			end
			S_SCAN: begin
				if (in_pair) begin
					key_b_q <= key_rd_q;
					res_x_q <= key_a_q.x;
					res_y_q <= key_a_q.y;
					span_q  <= (span == 16'd0) ? 16'd1 : span;
					rem_q   <= {1'b0, t_q - key_a_q.frame};
					quo_q   <= '0;
					cnt_q   <= '0;
				end else begin
					key_a_q <= key_rd_q;
					cur_q   <= cur_inc;
					i_q     <= i_q + 9'd1;
				end
			end
			S_DIV: begin
				rem_q <= ge ? (trial - {1'b0, span_q}) : trial;
				quo_q <= {quo_q[7:0], ge};
				cnt_q <= cnt_q + 4'd1;
			end
			S_SSU: begin
				quo_q <= prod_q[24:16];
			end
			S_MY: begin
				res_x_q <= key_a_q.x + prod_q[23:8];
			end
			S_FY: begin
				res_y_q <= key_a_q.y + prod_q[23:8];
			end
			S_OUT: begin
				if (out_free) begin
					m_tdata_q <= {res_y_q, res_x_q};
				end
			end
			default: begin
				res_x_q <= res_x_q;
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// File: design/lki_checker.sv
// Port checker for the layer keyframe interpolator, bound to the top level.
// Depends on lki_pkg and the macros in layer_keyframe_interpolator_top_assert.svh.
`include "layer_keyframe_interpolator_top_assert.svh"

module lki_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [lki_pkg::S_TUSER_W-1:0] s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [lki_pkg::M_TDATA_W-1:0] m_tdata
);

	// A result beat that is not taken stays put.
	`LKI_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output beat changed while stalled")

	// Store writes and unknown requests finish at once.
	`LKI_ASSERT_NEXT(a_write_ready, s_tvalid && s_tready && (s_tuser != lki_pkg::REQ_QUERY), s_tready, "not ready after a write beat")

	// A query always makes the engine busy in the cycle after it is taken.
	`LKI_ASSERT_NEXT(a_query_busy, s_tvalid && s_tready && (s_tuser == lki_pkg::REQ_QUERY), !s_tready, "ready right after a query beat")

	// A new result only appears when a query was in work.
	`LKI_ASSERT_NOW(a_result_src, $rose(m_tvalid), $past(s_tready) == 1'b0, "result without a query in work")

endmodule

bind layer_keyframe_interpolator_top lki_checker u_lki_checker (.*);
